// ===== design/efm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efm_pkg
// Shared types and constants of the event flood monitor.
// ----------------------------------------------------------------------------
package efm_pkg;

	localparam int TABLE_SLOTS_DEF = 64;
	localparam int PROBE_LIMIT_DEF = 8;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FLOOD_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = CFG_IDX_W'(1);

	localparam logic [31:0] FLOOD_LIMIT_RST = 32'd3000;
	localparam logic [15:0] WINDOW_LEN_RST  = 16'd1000;

	localparam logic [31:0] HASH_MULT = 32'h9E37_79B9;
	localparam int          HASH_FOLD = 16;
	localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [63:0] handle;
		logic [31:0] code;
		logic [31:0] count;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Control from the sequencer to the top-three tracker.
	typedef struct packed {
		logic clr;
		logic upd;
	} rank_ctl_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_HASH,
		ST_CHECK,
		ST_SCAN,
		ST_REPORT,
		ST_COUNT,
		ST_PROBE,
		ST_CHK
	} state_t;

endpackage

// ===== design/efm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/efm_rank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efm_rank
// Tracks the three slots with the largest counts while the table is swept.
// ----------------------------------------------------------------------------
module efm_rank
	import efm_pkg::*;
(
	input  logic      clk,
	input  rank_ctl_t ctl,
	input  slot_t     entry,
	output slot_t     rank0,
	output slot_t     rank1,
	output slot_t     rank2
);

	slot_t rank0_q;
	slot_t rank1_q;
	slot_t rank2_q;

	// Only a strictly larger count moves a rank, so on ties the lower slot stays ahead.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			rank0_q <= '0;
			rank1_q <= '0;
			rank2_q <= '0;
		end else if (ctl.upd && (entry.count != '0)) begin
			if (entry.count > rank0_q.count) begin
				rank2_q <= rank1_q;
				rank1_q <= rank0_q;
				rank0_q <= entry;
			end else if (entry.count > rank1_q.count) begin
				rank2_q <= rank1_q;
				rank1_q <= entry;
			end else if (entry.count > rank2_q.count) begin
				rank2_q <= entry;
			end
		end
	end

	assign rank0 = rank0_q;
	assign rank1 = rank1_q;
	assign rank2 = rank2_q;

endmodule

// ===== design/efm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efm_seq
// Sequencer: hashing, window check, table sweep and probing of the slot RAM.
// ----------------------------------------------------------------------------
module efm_seq
	import efm_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF,
	localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       timestamp_ms,
	input  logic [63:0]       source_handle,
	input  logic [31:0]       message_code,
	input  logic [31:0]       flood_limit,
	input  logic [15:0]       window_len,
	output logic              busy,
	output logic              report_valid,
	output logic [31:0]       window_total,
	output logic              ram_we,
	output logic [IDX_W-1:0]  ram_waddr,
	output slot_t             ram_wdata,
	output logic [IDX_W-1:0]  ram_raddr,
	input  slot_t             ram_rdata,
	output rank_ctl_t         rank_ctl
);

	localparam int SCN_W = $clog2(TABLE_SLOTS + 1);
	localparam int PRB_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [SCN_W-1:0] SCAN_END = SCN_W'(TABLE_SLOTS);
	localparam logic [SCN_W-1:0] CLR_LAST = SCN_W'(TABLE_SLOTS - 1);
	localparam logic [PRB_W-1:0] PRB_LAST = PRB_W'(PROBE_LIMIT - 1);

	state_t state_q;
	state_t state_d;

	logic [63:0]      ts_q;
	logic [63:0]      handle_q;
	logic [31:0]      code_q;
	logic [63:0]      prod_q;
	logic             close_q;
	logic [63:0]      start_ts_q;
	logic             started_q;
	logic [31:0]      total_q;
	logic [SCN_W-1:0] scan_q;
	logic             scan_vld_s1;
	logic [IDX_W-1:0] addr_q;
	logic [PRB_W-1:0] probe_q;
	logic             report_valid_q;
	logic [31:0]      wtotal_q;

	logic [63:0]      hash_x;
	logic [63:0]      hash_f;
	logic [IDX_W-1:0] home;
	logic [63:0]      elapsed;
	logic             slot_hit;
	logic [31:0]      cnt_inc;

	assign hash_x   = handle_q ^ prod_q;
	assign hash_f   = hash_x ^ (hash_x >> HASH_FOLD);
	assign home     = hash_f[IDX_W-1:0] & IDX_MASK;
	assign elapsed  = ts_q - start_ts_q;
	assign slot_hit = (ram_rdata.handle == handle_q) && (ram_rdata.code == code_q);
	assign cnt_inc  = (ram_rdata.count == CNT_MAX) ? CNT_MAX : ram_rdata.count + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		rank_ctl  = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q[IDX_W-1:0];
				if (scan_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (started_q && close_q) begin
					rank_ctl.clr = 1'b1;
					state_d      = ST_SCAN;
				end else begin
					state_d = ST_COUNT;
				end
			end
			ST_SCAN: begin
				// Each slot is read and zeroed in the same cycle; its old value
				// reaches the tracker in the next cycle.
				if (scan_q != SCAN_END) begin
					ram_raddr = scan_q[IDX_W-1:0];
					ram_we    = 1'b1;
					ram_waddr = scan_q[IDX_W-1:0];
				end
				rank_ctl.upd = scan_vld_s1;
				if ((scan_q == SCAN_END) && scan_vld_s1) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				ram_raddr = addr_q & IDX_MASK;
				state_d   = ST_CHK;
			end
			ST_CHK: begin
				ram_waddr = addr_q & IDX_MASK;
				if (ram_rdata.count == '0) begin
					ram_we    = 1'b1;
					ram_wdata = '{handle: handle_q, code: code_q, count: 32'd1};
					state_d   = ST_IDLE;
				end else if (slot_hit) begin
					ram_we    = 1'b1;
					ram_wdata = '{handle: ram_rdata.handle, code: ram_rdata.code,
						count: cnt_inc};
					state_d   = ST_IDLE;
				end else if (probe_q == PRB_LAST) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q         <= '0;
			scan_vld_s1    <= 1'b0;
			start_ts_q     <= '0;
			started_q      <= 1'b0;
			total_q        <= '0;
			probe_q        <= '0;
			report_valid_q <= 1'b0;
		end else begin
			report_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					scan_q <= scan_q + SCN_W'(1);
				end
				ST_CHECK: begin
					scan_q      <= '0;
					scan_vld_s1 <= 1'b0;
				end
				ST_SCAN: begin
					scan_vld_s1 <= (scan_q != SCAN_END);
					if (scan_q != SCAN_END) begin
						scan_q <= scan_q + SCN_W'(1);
					end
				end
				ST_REPORT: begin
					report_valid_q <= (total_q > flood_limit);
					total_q        <= '0;
					started_q      <= 1'b0;
				end
				ST_COUNT: begin
					if (!started_q) begin
						start_ts_q <= ts_q;
						started_q  <= 1'b1;
					end
					if (total_q != CNT_MAX) begin
						total_q <= total_q + 32'd1;
					end
					probe_q <= '0;
				end
				ST_CHK: begin
					probe_q <= probe_q + PRB_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ts_q     <= timestamp_ms;
					handle_q <= source_handle;
					code_q   <= message_code;
				end
			end
			ST_HASH: begin
				prod_q  <= code_q * HASH_MULT;
				close_q <= (elapsed >= {48'd0, window_len});
			end
			ST_REPORT: begin
				wtotal_q <= total_q;
			end
			ST_COUNT: begin
				addr_q <= home;
			end
			ST_CHK: begin
				addr_q <= addr_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign report_valid = report_valid_q;
	assign window_total = wtotal_q;

endmodule

// ===== design/event_flood_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flood_monitor
// Counts events per (handle, code) pair in a hashed slot table over a time
// window and reports the total and the three largest pairs on a flood.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  config    cfg_we               cfg_index, cfg_wdata
//  event     start / busy         timestamp_ms, source_handle, message_code
//  report    report_valid strobe  window_total, first_*, second_*, third_*
//
// An event passes the hash, check and count states and then probes the slot
// RAM, with its registered read, 1 to PROBE_LIMIT times, each probe a read
// state and a check state. An event that closes the window adds a sweep that
// ranks and clears every slot and a report state; a report comes out during
// that event. After reset the slot RAM is cleared with busy high.
// The report is a one-cycle strobe and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module event_flood_monitor
	import efm_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic [63:0]           timestamp_ms,
	input  logic [63:0]           source_handle,
	input  logic [31:0]           message_code,
	output logic                  report_valid,
	output logic [31:0]           window_total,
	output logic [63:0]           first_handle,
	output logic [31:0]           first_code,
	output logic [31:0]           first_count,
	output logic [63:0]           second_handle,
	output logic [31:0]           second_code,
	output logic [31:0]           second_count,
	output logic [63:0]           third_handle,
	output logic [31:0]           third_code,
	output logic [31:0]           third_count
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);

	logic [31:0]      flood_limit_q;
	logic [15:0]      window_len_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	slot_t            ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	slot_t            ram_rdata;
	rank_ctl_t        rank_ctl;
	slot_t            rank0;
	slot_t            rank1;
	slot_t            rank2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flood_limit_q <= FLOOD_LIMIT_RST;
			window_len_q  <= WINDOW_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLOOD_LIMIT: flood_limit_q <= cfg_wdata;
				REG_WINDOW_LEN:  window_len_q  <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	efm_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	efm_rank u_rank (
		.clk   (clk),
		.ctl   (rank_ctl),
		.entry (ram_rdata),
		.rank0 (rank0),
		.rank1 (rank1),
		.rank2 (rank2)
	);

	efm_seq #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.PROBE_LIMIT (PROBE_LIMIT)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.timestamp_ms  (timestamp_ms),
		.source_handle (source_handle),
		.message_code  (message_code),
		.flood_limit   (flood_limit_q),
		.window_len    (window_len_q),
		.busy          (busy),
		.report_valid  (report_valid),
		.window_total  (window_total),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.rank_ctl      (rank_ctl)
	);

	assign first_handle  = rank0.handle;
	assign first_code    = rank0.code;
	assign first_count   = rank0.count;
	assign second_handle = rank1.handle;
	assign second_code   = rank1.code;
	assign second_count  = rank1.count;
	assign third_handle  = rank2.handle;
	assign third_code    = rank2.code;
	assign third_count   = rank2.count;

	// A report is only raised while the closing event is still being counted.
	a_report_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> busy)
		else $error("report strobe outside of an event");

	a_report_over_limit: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> (window_total > flood_limit_q))
		else $error("report with total not above the flood limit");

	a_report_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> ((first_count >= second_count) && (second_count >= third_count)))
		else $error("report ranks out of order");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

endmodule
